@@ rtl/ofa_pkg.sv @@
// Shared types and constants for the overwrite ring FIFO with running mean.
// No dependencies; imported by every module of the block.
package ofa_pkg;

	localparam int unsigned DEPTH_DEF = 5;
	localparam int unsigned TAG_W     = 10;
	localparam int unsigned RATE_W    = 8;
	localparam int unsigned MEAN_W    = 8;
	localparam int unsigned FILL_W    = 3;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [RATE_W-1:0] rate;
	} entry_t;

endpackage

@@ rtl/ofa_ring_mem.sv @@
// Ring storage: one write port, one read port, registered read data.
// Depends on ofa_pkg (entry_t).
module ofa_ring_mem #(
	parameter int unsigned DEPTH = ofa_pkg::DEPTH_DEF,
	parameter int unsigned AW    = 3
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  ofa_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output ofa_pkg::entry_t rdata
);
	import ofa_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/ofa_div.sv @@
// Restoring divider, one quotient bit per cycle; quotient is known to fit MEAN_W bits.
// Depends on ofa_pkg (MEAN_W).
module ofa_div #(
	parameter int unsigned NW = 12,
	parameter int unsigned DW = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NW-1:0]              num,
	input  logic [DW-1:0]              den,
	output logic                       done,
	output logic [ofa_pkg::MEAN_W-1:0] quot
);
	import ofa_pkg::*;

	localparam int unsigned WW = (NW > DW + MEAN_W - 1) ? NW : DW + MEAN_W - 1;
	localparam int unsigned KW = (MEAN_W > 1) ? $clog2(MEAN_W) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(MEAN_W - 1);

	logic              run_q;
	logic              done_q;
	logic [KW-1:0]     cnt_q;
	logic [WW-1:0]     rem_q;
	logic [WW-1:0]     dsh_q;
	logic [MEAN_W-1:0] quot_q;
	logic              ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == K_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// divisor starts aligned to the top quotient bit and walks down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= WW'(num);
			dsh_q <= WW'(den) << (MEAN_W - 1);
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[MEAN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/overwrite_ring_fifo_average_top.sv @@
// Overwrite ring FIFO with running mean: one transaction at a time.
// Remove: result strobe from ST_READ; the next start is taken back in ST_IDLE.
// Insert: result strobe in ST_DIV once the 8-step divider finishes, and the next
// start is taken back in ST_IDLE. The receiver cannot stall; done lasts one cycle.
// Reset clears indices, count and running sum; ring contents stay unwritten.
// Depends on ofa_pkg, ofa_ring_mem, ofa_div.
module overwrite_ring_fifo_average_top #(
	parameter int unsigned DEPTH = ofa_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [ofa_pkg::TAG_W-1:0]  item_tag,
	input  logic [ofa_pkg::RATE_W-1:0] rate_value,
	output logic                       done,
	output logic                       status,
	output logic [ofa_pkg::MEAN_W-1:0] mean_rate,
	output logic [ofa_pkg::TAG_W-1:0]  removed_tag,
	output logic [ofa_pkg::RATE_W-1:0] removed_rate,
	output logic [ofa_pkg::FILL_W-1:0] fill_level
);
	import ofa_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = RATE_W + CW;
	localparam int unsigned NW = SW + 1;
	localparam int unsigned DW = CW + 1;
	localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0]        state_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     sum_q;
	logic              cmd_q;
	logic [TAG_W-1:0]  tag_q;
	logic [RATE_W-1:0] rate_q;

	logic              done_q;
	logic              status_q;
	logic [MEAN_W-1:0] mean_q;
	logic [TAG_W-1:0]  rtag_q;
	logic [RATE_W-1:0] rrate_q;

	entry_t            rd_entry;
	entry_t            wr_entry;
	logic              mem_we;
	logic              full;
	logic [CW-1:0]     ins_count;
	logic [SW-1:0]     ins_sum;
	logic [AW-1:0]     head_nxt;
	logic [AW-1:0]     tail_nxt;
	logic              div_start;
	logic              div_done;
	logic [MEAN_W-1:0] div_quot;
	logic [NW-1:0]     div_num;
	logic [DW-1:0]     div_den;

	assign full      = count_q == CNT_FULL;
	assign head_nxt  = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign tail_nxt  = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	// a full ring drops its oldest rate before the new one goes in
	assign ins_count = full ? count_q : count_q + 1'b1;
	assign ins_sum   = sum_q - (full ? SW'(rd_entry.rate) : '0) + SW'(rate_q);
	assign div_num   = {ins_sum, 1'b0} + NW'(ins_count);
	assign div_den   = {ins_count, 1'b0};
	assign div_start = (state_q == ST_READ) && (cmd_q == CMD_INSERT);
	assign mem_we    = div_start;
	assign wr_entry  = '{tag: tag_q, rate: rate_q};

	ofa_ring_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (wr_entry),
		.raddr (head_q),
		.rdata (rd_entry)
	);

	ofa_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q  <= cmd;
			tag_q  <= item_tag;
			rate_q <= rate_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			sum_q    <= '0;
			done_q   <= 1'b0;
			status_q <= STATUS_OK;
			mean_q   <= '0;
			rtag_q   <= '0;
			rrate_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (cmd_q == CMD_INSERT) begin
						if (full) begin
							head_q <= head_nxt;
						end
						tail_q  <= tail_nxt;
						count_q <= ins_count;
						sum_q   <= ins_sum;
						state_q <= ST_DIV;
					end else begin
						done_q  <= 1'b1;
						mean_q  <= '0;
						state_q <= ST_IDLE;
						if (count_q == '0) begin
							status_q <= STATUS_EMPTY;
							rtag_q   <= '0;
							rrate_q  <= '0;
						end else begin
							status_q <= STATUS_OK;
							rtag_q   <= rd_entry.tag;
							rrate_q  <= rd_entry.rate;
							head_q   <= head_nxt;
							count_q  <= count_q - 1'b1;
							sum_q    <= sum_q - SW'(rd_entry.rate);
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						done_q   <= 1'b1;
						status_q <= STATUS_OK;
						mean_q   <= div_quot;
						rtag_q   <= '0;
						rrate_q  <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign status       = status_q;
	assign mean_rate    = mean_q;
	assign removed_tag  = rtag_q;
	assign removed_rate = rrate_q;
	assign fill_level   = FILL_W'(count_q);

endmodule
